/* hw/rtl/servo_angle_mapper_feedback_check_unit_assert.svh */
// ----------------------------------------------------------------------------
// Servo mapper assertion macros
// Shared macros for the concurrent checks of the servo mapper.
// ----------------------------------------------------------------------------
`ifndef SERVO_ANGLE_MAPPER_FEEDBACK_CHECK_UNIT_ASSERT_SVH
`define SERVO_ANGLE_MAPPER_FEEDBACK_CHECK_UNIT_ASSERT_SVH

// Check that is switched off while reset is held
`define SAMFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also runs during reset
`define SAMFC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/samfc_pkg.sv */
// ----------------------------------------------------------------------------
// Servo mapper package
// Widths, codes and shared types of the servo angle mapper.
// ----------------------------------------------------------------------------
package samfc_pkg;

    // Field and datapath widths
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SAMPLE_MAX_W    = 16;
    localparam int CFG_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int ANGLE_W         = 17;
    localparam int PULSE_W         = 15;
    localparam int LINK_W          = 2;
    localparam int OP_W            = 18;
    localparam int ACC_W           = 2 * OP_W;
    localparam int DIV_NW          = 34;
    localparam int DIV_DW          = 17;
    localparam int ANG_W           = 37;

    // Link tolerance (5 degrees) and measured angle saturation
    localparam int ANGLE_TOL = 1280;
    localparam int MEAS_MAX  = 65535;
    localparam int MEAS_MIN  = -65536;

    typedef enum logic [1:0] {
        CMD_SET_ANGLE = 2'd0,
        CMD_SET_PULSE = 2'd1,
        CMD_CHECK     = 2'd2,
        CMD_RELEASE   = 2'd3
    } t_cmd;

    typedef enum logic [LINK_W-1:0] {
        LINK_UNCHECKED = 2'd0,
        LINK_OK        = 2'd1,
        LINK_LOST      = 2'd2
    } t_link;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_LOW  = 3'd0,
        REG_ANGLE_HIGH = 3'd1,
        REG_PULSE_LOW  = 3'd2,
        REG_PULSE_CTR  = 3'd3,
        REG_PULSE_HIGH = 3'd4,
        REG_FB_LOW     = 3'd5,
        REG_FB_HIGH    = 3'd6,
        REG_DIR_INV    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DIV_WAIT,
        ST_FB_SIGN,
        ST_FB_CHECK,
        ST_FINISH
    } t_state;

    // Calibration registers as seen by the datapath
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_low;
        logic [15:0]               angle_high;
        logic [PULSE_W-1:0]        pulse_low;
        logic [PULSE_W-1:0]        pulse_center;
        logic [PULSE_W-1:0]        pulse_high;
        logic [SAMPLE_MAX_W-1:0]   fb_low;
        logic [SAMPLE_MAX_W-1:0]   fb_high;
        logic                      dir_inv;
    } t_cfg;

endpackage

/* hw/rtl/samfc_if.sv */
// ----------------------------------------------------------------------------
// Servo mapper channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface samfc_in_if
    import samfc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic signed [ANGLE_W-1:0] target_angle;
    logic [PULSE_W-1:0]        target_pulse;
    logic [SAMPLE_BITS-1:0]    feedback_sample;

    modport source (
        output valid, command, target_angle, target_pulse, feedback_sample,
        input  ready
    );
    modport sink (
        input  valid, command, target_angle, target_pulse, feedback_sample,
        output ready
    );
endinterface

interface samfc_out_if
    import samfc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [PULSE_W-1:0]        compare_us;
    logic signed [ANGLE_W-1:0] measured_angle;
    logic [LINK_W-1:0]         link_status;

    modport source (
        output valid, compare_us, measured_angle, link_status,
        input  ready
    );
    modport sink (
        input  valid, compare_us, measured_angle, link_status,
        output ready
    );
endinterface

/* hw/rtl/samfc_cfg.sv */
// ----------------------------------------------------------------------------
// Servo mapper register bank
// Calibration registers written through the plain write port.
// ----------------------------------------------------------------------------
module samfc_cfg
    import samfc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    // Feedback registers keep 12 bits, further limited to the sample width
    localparam logic [SAMPLE_MAX_W-1:0] SMASK =
        SAMPLE_MAX_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    t_cfg                    r_cfg;
    logic [SAMPLE_MAX_W-1:0] fb_val;

    assign fb_val = SAMPLE_MAX_W'(i_data[11:0]) & SMASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_low    <= ANGLE_W'(-7680);
            r_cfg.angle_high   <= 16'd7680;
            r_cfg.pulse_low    <= PULSE_W'(1000);
            r_cfg.pulse_center <= PULSE_W'(1500);
            r_cfg.pulse_high   <= PULSE_W'(2000);
            r_cfg.fb_low       <= '0;
            r_cfg.fb_high      <= SAMPLE_MAX_W'(4095) & SMASK;
            r_cfg.dir_inv      <= 1'b0;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_ANGLE_LOW:  r_cfg.angle_low    <= $signed(i_data);
                REG_ANGLE_HIGH: r_cfg.angle_high   <= i_data[15:0];
                REG_PULSE_LOW:  r_cfg.pulse_low    <= i_data[PULSE_W-1:0];
                REG_PULSE_CTR:  r_cfg.pulse_center <= i_data[PULSE_W-1:0];
                REG_PULSE_HIGH: r_cfg.pulse_high   <= i_data[PULSE_W-1:0];
                REG_FB_LOW:     r_cfg.fb_low       <= fb_val;
                REG_FB_HIGH:    r_cfg.fb_high      <= fb_val;
                REG_DIR_INV:    r_cfg.dir_inv      <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/samfc_div.sv */
// ----------------------------------------------------------------------------
// Servo mapper serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module samfc_div
    import samfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;

    // Shift in the next numerator bit and try a subtract
    assign trial = {r_rem, r_num[DIV_NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits replace numerator bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], fits};
            r_rem <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* hw/rtl/servo_angle_mapper_feedback_check_unit.sv */
// ----------------------------------------------------------------------------
// Servo angle mapper with feedback check
// Maps commanded angles to pulse widths and checks position feedback.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake         Payload
//  i_in     in   valid/ready       command, target_angle, target_pulse,
//                                  feedback_sample
//  o_out    out  valid/ready       compare_us, measured_angle, link_status
//  i_cfg_*  in   write enable      i_cfg_idx, i_cfg_data
//
//  Set angle: PREP, MUL1, MUL2, DIV, DIV_WAIT (DIV exits early when the
//  mapped numerator is not positive, MUL1 for a zero angle); check feedback:
//  PREP, MUL1, DIV, DIV_WAIT, FB_SIGN, FB_CHECK (MUL1 exits for a zero span);
//  set pulse, release: PREP. All end in FINISH. 34-step serial divider; one
//  item in flight; results wait in the output register while new items enter.
//  Reset is synchronous, active low, and restores the calibration defaults.
// ----------------------------------------------------------------------------
module servo_angle_mapper_feedback_check_unit
    import samfc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    samfc_in_if.sink             i_in,
    samfc_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg cfg;

    samfc_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Clamp a nonnegative value to the pulse limits, high limit last
    function automatic logic [PULSE_W-1:0] clamp_pulse(
        input logic [DIV_NW-1:0]  p,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        logic [DIV_NW-1:0] v;
        v = p;
        if (v < DIV_NW'(lo)) v = DIV_NW'(lo);
        if (v > DIV_NW'(hi)) v = DIV_NW'(hi);
        return v[PULSE_W-1:0];
    endfunction

    t_state                     r_state, n_state;
    t_cmd                       r_cmd;
    logic signed [ANGLE_W-1:0]  r_ta;
    logic [PULSE_W-1:0]         r_tp;
    logic [SAMPLE_MAX_W-1:0]    r_fs;
    logic signed [OP_W-1:0]     r_a;
    logic signed [OP_W-1:0]     r_sd;
    logic signed [OP_W-1:0]     r_span;
    logic                       r_win_bad;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_neg;
    logic signed [ANG_W-1:0]    r_ang;
    logic [PULSE_W-1:0]         r_res_pulse;
    logic signed [ANGLE_W-1:0]  r_meas;
    t_link                      r_new_link;

    logic [PULSE_W-1:0]         r_held_pulse;
    logic signed [ANGLE_W-1:0]  r_held_angle;
    t_link                      r_link;

    logic                       r_o_valid;
    logic [PULSE_W-1:0]         r_o_pulse;
    logic signed [ANGLE_W-1:0]  r_o_meas;
    t_link                      r_o_link;

    logic                       in_acc;
    logic                       fin_go;
    logic signed [OP_W-1:0]     ta_ext, a_inv, a_lo, a_clamp;
    logic signed [OP_W-1:0]     lo_ext, hi_ext, d_neg, c_ext, pl_ext, ph_ext;
    logic signed [OP_W-1:0]     s_ext, fl_ext, fh_ext;
    logic [20:0]                win_s1, win_s0, win_fl, win_fh;
    logic                       win_bad;
    logic signed [OP_W-1:0]     mul_a, mul_b;
    logic signed [ACC_W-1:0]    mul_p;
    logic signed [ACC_W-1:0]    acc_abs;
    logic signed [OP_W-1:0]     span_abs;
    logic                       div_start, div_done;
    logic [DIV_NW-1:0]          div_num, div_quot;
    logic [DIV_DW-1:0]          div_den;
    logic signed [ANG_W-1:0]    q_signed;
    logic signed [ANG_W-1:0]    dev;
    logic                       dev_ok;
    logic signed [ANGLE_W-1:0]  meas_sat;
    logic                       is_angle;

    assign in_acc   = i_in.valid & i_in.ready;
    assign fin_go   = (r_state == ST_FINISH) && (!r_o_valid || o_out.ready);
    assign is_angle = (r_cmd == CMD_SET_ANGLE);

    // Angle negate and clamp, low limit first
    assign ta_ext  = OP_W'(r_ta);
    assign a_inv   = cfg.dir_inv ? -ta_ext : ta_ext;
    assign lo_ext  = OP_W'(cfg.angle_low);
    assign hi_ext  = $signed(OP_W'(cfg.angle_high));
    assign a_lo    = (a_inv < lo_ext) ? lo_ext : a_inv;
    assign a_clamp = (a_lo > hi_ext) ? hi_ext : a_lo;
    assign d_neg   = -lo_ext;
    assign c_ext   = $signed(OP_W'(cfg.pulse_center));
    assign pl_ext  = $signed(OP_W'(cfg.pulse_low));
    assign ph_ext  = $signed(OP_W'(cfg.pulse_high));

    // Feedback differences and the one-tenth window
    assign s_ext   = $signed(OP_W'(r_fs));
    assign fl_ext  = $signed(OP_W'(cfg.fb_low));
    assign fh_ext  = $signed(OP_W'(cfg.fb_high));
    assign win_s1  = 21'd10 * (21'(r_fs) + 21'd1);
    assign win_s0  = 21'd10 * 21'(r_fs);
    assign win_fl  = 21'd9 * 21'(cfg.fb_low);
    assign win_fh  = 21'd11 * 21'(cfg.fb_high);
    assign win_bad = (win_s1 <= win_fl) || (win_fh < win_s0);

    // Shared multiplier
    always_comb begin
        mul_a = c_ext;
        mul_b = hi_ext;
        if (r_state == ST_MUL2) begin
            mul_a = (r_a < 0) ? (c_ext - pl_ext) : (ph_ext - c_ext);
            mul_b = r_a;
        end else if (is_angle) begin
            mul_a = c_ext;
            mul_b = (r_a < 0) ? d_neg : hi_ext;
        end else begin
            mul_a = hi_ext - lo_ext;
            mul_b = r_sd;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Divider operands: magnitudes, sign handled around the divider
    assign acc_abs   = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign span_abs  = r_span[OP_W-1] ? -r_span : r_span;
    assign div_num   = acc_abs[DIV_NW-1:0];
    assign div_den   = !is_angle ? span_abs[DIV_DW-1:0] :
                       (r_a < 0) ? d_neg[DIV_DW-1:0] : DIV_DW'(cfg.angle_high);
    assign div_start = (r_state == ST_DIV) && (!is_angle || (r_acc > 0));

    samfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Measured angle: signed quotient, tolerance test and saturation
    assign q_signed = r_neg ? -$signed(ANG_W'(div_quot)) : $signed(ANG_W'(div_quot));
    assign dev      = r_ang - ANG_W'(r_held_angle);
    assign dev_ok   = (dev <= ANG_W'(ANGLE_TOL)) && (dev >= -ANG_W'(ANGLE_TOL));
    assign meas_sat = (r_ang > ANG_W'(MEAS_MAX)) ? ANGLE_W'(MEAS_MAX) :
                      (r_ang < ANG_W'(MEAS_MIN)) ? ANGLE_W'(MEAS_MIN) :
                      r_ang[ANGLE_W-1:0];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_PREP;
            end
            ST_PREP: begin
                if (r_cmd == CMD_SET_ANGLE || r_cmd == CMD_CHECK) begin
                    n_state = ST_MUL1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_MUL1: begin
                if (is_angle) begin
                    n_state = (r_a == 0) ? ST_FINISH : ST_MUL2;
                end else begin
                    n_state = (r_span == 0) ? ST_FINISH : ST_DIV;
                end
            end
            ST_MUL2:     n_state = ST_DIV;
            ST_DIV:      n_state = div_start ? ST_DIV_WAIT : ST_FINISH;
            ST_DIV_WAIT: begin
                if (div_done) n_state = is_angle ? ST_FINISH : ST_FB_SIGN;
            end
            ST_FB_SIGN:  n_state = ST_FB_CHECK;
            ST_FB_CHECK: n_state = ST_FINISH;
            ST_FINISH: begin
                if (fin_go) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_cmd <= t_cmd'(i_in.command);
                    r_ta  <= i_in.target_angle;
                    r_tp  <= i_in.target_pulse;
                    r_fs  <= SAMPLE_MAX_W'(i_in.feedback_sample);
                end
            end
            ST_PREP: begin
                r_meas      <= '0;
                r_a         <= a_clamp;
                r_sd        <= s_ext - fl_ext;
                r_span      <= fh_ext - fl_ext;
                r_win_bad   <= win_bad;
                r_new_link  <= LINK_LOST;
                r_res_pulse <= (r_cmd == CMD_SET_PULSE) ?
                               clamp_pulse(DIV_NW'(r_tp), cfg.pulse_low, cfg.pulse_high) :
                               '0;
            end
            ST_MUL1: begin
                r_acc       <= mul_p;
                r_neg       <= mul_p[ACC_W-1] ^ r_span[OP_W-1];
                r_res_pulse <= clamp_pulse(DIV_NW'(cfg.pulse_center),
                                           cfg.pulse_low, cfg.pulse_high);
            end
            ST_MUL2: begin
                r_acc <= r_acc + mul_p;
            end
            ST_DIV: begin
                r_res_pulse <= clamp_pulse('0, cfg.pulse_low, cfg.pulse_high);
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    r_res_pulse <= clamp_pulse(div_quot, cfg.pulse_low, cfg.pulse_high);
                    r_ang       <= ANG_W'(lo_ext) + q_signed;
                end
            end
            ST_FB_SIGN: begin
                r_ang <= cfg.dir_inv ? -r_ang : r_ang;
            end
            ST_FB_CHECK: begin
                r_meas     <= meas_sat;
                r_new_link <= (dev_ok && !r_win_bad) ? LINK_OK : LINK_LOST;
            end
            default: ;
        endcase
    end

    // Held state, updated when the result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pulse <= '0;
            r_held_angle <= '0;
            r_link       <= LINK_UNCHECKED;
        end else if (fin_go) begin
            if (r_cmd != CMD_CHECK) r_held_pulse <= r_res_pulse;
            if (r_cmd == CMD_SET_ANGLE) r_held_angle <= r_ta;
            if (r_cmd == CMD_CHECK) r_link <= r_new_link;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fin_go) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_o_pulse <= (r_cmd == CMD_CHECK) ? r_held_pulse : r_res_pulse;
            r_o_meas  <= r_meas;
            r_o_link  <= (r_cmd == CMD_CHECK) ? r_new_link : r_link;
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.compare_us     = r_o_pulse;
    assign o_out.measured_angle = r_o_meas;
    assign o_out.link_status    = r_o_link;

endmodule

/* hw/rtl/samfc_chk.sv */
// ----------------------------------------------------------------------------
// Servo mapper port checks
// Concurrent checks on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "servo_angle_mapper_feedback_check_unit_assert.svh"

module samfc_chk
    import samfc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [PULSE_W-1:0] i_out_pulse,
    input logic [ANGLE_W-1:0] i_out_meas,
    input logic [LINK_W-1:0]  i_out_link
);

    // One item at a time: busy right after an accept
    `SAMFC_ASSERT(a_busy_after_accept,
        (i_in_valid && i_in_ready) |=> !i_in_ready,
        "ready after accept")

    // Reset empties the output register
    `SAMFC_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A nonzero measured angle only comes from a feedback check
    `SAMFC_ASSERT(a_meas_needs_check,
        (i_out_valid && i_out_meas != '0) |-> (i_out_link != LINK_UNCHECKED),
        "angle without check")

    // A stalled result holds
    `SAMFC_ASSERT(a_out_hold,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pulse)
            && $stable(i_out_meas) && $stable(i_out_link)),
        "stalled result changed")

endmodule

bind servo_angle_mapper_feedback_check_unit samfc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pulse (o_out.compare_us),
    .i_out_meas  (o_out.measured_angle),
    .i_out_link  (o_out.link_status)
);
